### rtl/rtch_pkg.sv
// rtch_pkg: widths, types and helpers shared by the ray/triangle closest-hit core.
// Depends on nothing; imported by rtch_mac, rtch_div and the top level.
package rtch_pkg;

	localparam int CW    = 32;                 // coordinate width
	localparam int FB    = 16;                 // fraction bits
	localparam int IW    = 16;                 // triangle id width
	localparam int DW    = CW - 1;             // distance width
	localparam int UW    = FB + 1;             // barycentric width
	localparam int OPW   = CW + 2;             // multiplier operand width
	localparam int PW    = 2 * OPW;            // product width
	localparam int VW    = 2 * CW + 2;         // cross product component width
	localparam int AW    = 3 * CW + 4;         // accumulator width
	localparam int QT    = CW;                 // quotient bits of t
	localparam int RW    = AW + FB;            // divider remainder width
	localparam int DNW   = AW + QT - 1;        // divider shifted divisor width
	localparam int CNTW  = $clog2(QT);
	localparam int IN_W  = IW + 9 * CW;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = DW + 2 * UW + IW;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
	localparam int CFG_IW = 3;

	localparam logic [CW-1:0] DIR_Z_RESET = CW'(1) << FB;
	localparam logic [DW-1:0] LIMIT_RESET = DW'(1) << FB;

	typedef enum logic [CFG_IW-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z,
		REG_START_LIMIT
	} reg_index_t;

	typedef struct packed {
		logic en;
		logic clear;
		logic hi;
		logic neg;
	} mac_ctrl_t;

	function automatic logic [1:0] next3(input logic [1:0] c);
		return (c == 2'd2) ? 2'd0 : c + 2'd1;
	endfunction

endpackage

### rtl/rtch_mac.sv
// rtch_mac: shared signed multiply-accumulate unit of the closest-hit core.
// One OPW x OPW product per cycle while ctrl.en is set, optionally negated and shifted by one limb.
// Depends on rtch_pkg.
module rtch_mac (
	input  logic                                clk,
	input  rtch_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [rtch_pkg::OPW-1:0]     op_a,
	input  logic signed [rtch_pkg::OPW-1:0]     op_b,
	output logic signed [rtch_pkg::AW-1:0]      acc
);
	import rtch_pkg::*;

	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] ext;
	logic signed [AW-1:0] term;
	logic signed [AW-1:0] base;
	logic signed [AW-1:0] acc_q;

	always_comb begin
		prod = op_a * op_b;
		ext  = {{(AW-PW){prod[PW-1]}}, prod};
		term = ctrl.hi ? (ext <<< CW) : ext;
		if (ctrl.neg) begin
			term = -term;
		end
		base = ctrl.clear ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= base + term;
		end
	end

	assign acc = acc_q;

endmodule

### rtl/rtch_div.sv
// rtch_div: restoring divider, one quotient bit per cycle, for t, u and v.
// Quotient = floor(num * 2^FB / den), num >= 0, den > 0, quotient known to fit.
// Depends on rtch_pkg.
module rtch_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         long_div,
	input  logic [rtch_pkg::AW-1:0]      num,
	input  logic [rtch_pkg::AW-1:0]      den,
	output logic                         busy,
	output logic                         done,
	output logic [rtch_pkg::QT-1:0]      quo
);
	import rtch_pkg::*;

	logic [RW-1:0]   rem_q;
	logic [DNW-1:0]  den_q;
	logic [QT-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            ge;

	assign ge = {{(DNW-RW){1'b0}}, rem_q} >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= long_div ? CNTW'(QT - 1) : CNTW'(UW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {num, {FB{1'b0}}};
			den_q <= long_div ? {den, {(QT-1){1'b0}}}
			                  : {{(QT-UW){1'b0}}, den, {(UW-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q[RW-1:0];
			end
			quo_q <= {quo_q[QT-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/ray_triangle_closest_hit_core.sv
// Closest-hit search of one ray against a stream of triangles (Moller-Trumbore,
// two-sided, exact fixed point). Each triangle runs both cross products and the four
// dot products on the single shared multiply-accumulate unit, then the settle, sign
// fold and range test states; a zero determinant skips the range tests. A triangle
// that passes them goes to the one-bit-per-cycle divider for t and, if t is within the
// current best distance, for u and v. Every triangle ends in the finish state and
// returns to idle. The input is not ready while a triangle is in work.
// The result of a final triangle waits in an output register while the next ray's
// triangles are taken. Any write to one of the seven ray registers re-arms.
// Depends on rtch_pkg, rtch_mac and rtch_div.
module ray_triangle_closest_hit_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// tri_index, vert_x, vert_y, vert_z, edge_ab_x/y/z, edge_ac_x/y/z
	input  logic [rtch_pkg::IN_TW-1:0]      s_axis_tdata,
	input  logic                            s_axis_tlast,   // final_tri
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// hit_dist, bary_u, bary_v, hit_index, zero fill
	output logic [rtch_pkg::OUT_TW-1:0]     m_axis_tdata,
	output logic                            m_axis_tuser,   // found
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rtch_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [rtch_pkg::CW-1:0]         cfg_data
);
	import rtch_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CROSS_P, ST_CROSS_Q, ST_DOT, ST_SETTLE, ST_NORM, ST_TEST,
		ST_DIV_T, ST_DIV_U, ST_DIV_V, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {PH_DET, PH_UN, PH_VN, PH_TN} phase_t;

	typedef enum logic [2:0] {
		DST_PV, DST_QV, DST_DET, DST_UN, DST_VN, DST_TN
	} dst_t;

	typedef struct packed {
		logic       valid;
		dst_t       dst;
		logic [1:0] idx;
	} store_t;

	state_t  state_q;
	phase_t  phase_q;
	logic [1:0] c_q;
	logic       h_q;
	store_t  store_s1;

	logic signed [CW-1:0] org_q [3];
	logic signed [CW-1:0] dir_q [3];
	logic [DW-1:0]        limit_q;

	logic [DW-1:0] best_dist_q;
	logic [UW-1:0] best_u_q;
	logic [UW-1:0] best_v_q;
	logic [IW-1:0] best_index_q;
	logic          any_hit_q;

	logic          out_valid_q;
	logic          out_found_q;
	logic [OUT_W-1:0] out_data_q;

	logic [IW-1:0]        tri_q;
	logic                 final_q;
	logic signed [CW-1:0] e1_q [3];
	logic signed [CW-1:0] e2_q [3];
	logic signed [CW:0]   tv_q [3];
	logic signed [VW-1:0] pv_q [3];
	logic signed [VW-1:0] qv_q [3];
	logic signed [AW-1:0] det_q, un_q, vn_q, tn_q;
	logic [QT-1:0]        t_q;
	logic [UW-1:0]        u_q;

	logic signed [OPW-1:0] vd [3];
	logic signed [OPW-1:0] ve1 [3];
	logic signed [OPW-1:0] ve2 [3];
	logic signed [OPW-1:0] vtv [3];

	mac_ctrl_t             mac_ctrl;
	logic signed [OPW-1:0] op_a, op_b;
	logic signed [VW-1:0]  bw;
	logic signed [AW-1:0]  acc;
	logic [1:0]            ia, ib;

	logic          div_start, div_long, div_busy, div_done;
	logic [AW-1:0] div_num;
	logic [QT-1:0] div_quo;

	logic            accept, last_op, pass, t_ok, commit;
	logic [AW:0]     uv_sum;
	logic signed [CW:0] tv_new [3];

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {{(OUT_TW-OUT_W){1'b0}}, out_data_q};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vd[i]  = {{(OPW-CW){dir_q[i][CW-1]}}, dir_q[i]};
			ve1[i] = {{(OPW-CW){e1_q[i][CW-1]}}, e1_q[i]};
			ve2[i] = {{(OPW-CW){e2_q[i][CW-1]}}, e2_q[i]};
			vtv[i] = {{(OPW-CW-1){tv_q[i][CW]}}, tv_q[i]};
			tv_new[i] = {org_q[i][CW-1], org_q[i]}
			          - {s_axis_tdata[IW+CW*(i+1)-1], s_axis_tdata[IW+CW*i +: CW]};
		end
	end

	// operand selection for the shared multiply-accumulate unit
	always_comb begin
		ia       = h_q ? next3(next3(c_q)) : next3(c_q);
		ib       = h_q ? next3(c_q) : next3(next3(c_q));
		op_a     = '0;
		op_b     = '0;
		bw       = '0;
		mac_ctrl = '0;
		unique case (state_q)
			ST_CROSS_P: begin
				op_a     = vd[ia];
				op_b     = ve2[ib];
				mac_ctrl = '{en: 1'b1, clear: !h_q, hi: 1'b0, neg: h_q};
			end
			ST_CROSS_Q: begin
				op_a     = vtv[ia];
				op_b     = ve1[ib];
				mac_ctrl = '{en: 1'b1, clear: !h_q, hi: 1'b0, neg: h_q};
			end
			ST_DOT: begin
				unique case (phase_q)
					PH_DET: begin op_a = ve1[c_q]; bw = pv_q[c_q]; end
					PH_UN:  begin op_a = vtv[c_q]; bw = pv_q[c_q]; end
					PH_VN:  begin op_a = vd[c_q];  bw = qv_q[c_q]; end
					PH_TN:  begin op_a = ve2[c_q]; bw = qv_q[c_q]; end
					default: ;
				endcase
				op_b     = h_q ? bw[VW-1:CW] : {2'b00, bw[CW-1:0]};
				mac_ctrl = '{en: 1'b1, clear: (c_q == 2'd0) && !h_q, hi: h_q, neg: 1'b0};
			end
			default: ;
		endcase
	end

	rtch_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	// range tests on the sign-folded numerators
	always_comb begin
		uv_sum = {un_q[AW-1], un_q} + {vn_q[AW-1], vn_q};
		pass = !un_q[AW-1] && !(det_q < un_q) && !vn_q[AW-1]
		    && !($signed({det_q[AW-1], det_q}) < $signed(uv_sum)) && !tn_q[AW-1]
		    && ({{(QT-FB){1'b0}}, tn_q} < {det_q, {(QT-FB){1'b0}}});
		t_ok   = div_quo <= {1'b0, best_dist_q};
		last_op = h_q && (c_q == 2'd2);
		commit = (state_q == ST_DIV_V) && div_done;
		div_start = ((state_q == ST_TEST) && pass)
		         || ((state_q == ST_DIV_T) && div_done && t_ok)
		         || ((state_q == ST_DIV_U) && div_done);
		div_long = (state_q == ST_TEST);
		unique case (state_q)
			ST_TEST:  div_num = tn_q;
			ST_DIV_T: div_num = un_q;
			default:  div_num = vn_q;
		endcase
	end

	rtch_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.long_div (div_long),
		.num      (div_num),
		.den      (det_q),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo)
	);

	// sequencer, configuration, running best and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_DET;
			c_q          <= '0;
			h_q          <= 1'b0;
			store_s1     <= '0;
			org_q[0]     <= '0;
			org_q[1]     <= '0;
			org_q[2]     <= '0;
			dir_q[0]     <= '0;
			dir_q[1]     <= '0;
			dir_q[2]     <= DIR_Z_RESET;
			limit_q      <= LIMIT_RESET;
			best_dist_q  <= LIMIT_RESET;
			best_u_q     <= '0;
			best_v_q     <= '0;
			best_index_q <= '0;
			any_hit_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && !(state_q == ST_FINISH && final_q)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (reg_index_t'(cfg_index))
					REG_ORIGIN_X:    org_q[0] <= cfg_data;
					REG_ORIGIN_Y:    org_q[1] <= cfg_data;
					REG_ORIGIN_Z:    org_q[2] <= cfg_data;
					REG_DIR_X:       dir_q[0] <= cfg_data;
					REG_DIR_Y:       dir_q[1] <= cfg_data;
					REG_DIR_Z:       dir_q[2] <= cfg_data;
					REG_START_LIMIT: limit_q  <= cfg_data[DW-1:0];
					default: ;
				endcase
				if (cfg_index <= REG_START_LIMIT) begin
					best_dist_q  <= (reg_index_t'(cfg_index) == REG_START_LIMIT)
					              ? cfg_data[DW-1:0] : limit_q;
					best_u_q     <= '0;
					best_v_q     <= '0;
					best_index_q <= '0;
					any_hit_q    <= 1'b0;
				end
			end
			if ((state_q == ST_CROSS_P || state_q == ST_CROSS_Q) && h_q) begin
				store_s1 <= '{valid: 1'b1,
				              dst: (state_q == ST_CROSS_P) ? DST_PV : DST_QV, idx: c_q};
			end else if (state_q == ST_DOT && last_op) begin
				store_s1 <= '{valid: 1'b1, dst: dst_t'(3'(phase_q) + 3'd2), idx: c_q};
			end else begin
				store_s1.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CROSS_P;
						c_q     <= '0;
						h_q     <= 1'b0;
						phase_q <= PH_DET;
					end
				end
				ST_CROSS_P, ST_CROSS_Q, ST_DOT: begin
					h_q <= !h_q;
					if (h_q) begin
						c_q <= next3(c_q);
					end
					if (last_op) begin
						if (state_q == ST_CROSS_P) begin
							state_q <= ST_CROSS_Q;
						end else if (state_q == ST_CROSS_Q) begin
							state_q <= ST_DOT;
						end else if (phase_q == PH_TN) begin
							state_q <= ST_SETTLE;
						end else begin
							phase_q <= phase_t'(phase_q + 2'd1);
						end
					end
				end
				ST_SETTLE: state_q <= ST_NORM;
				ST_NORM:   state_q <= (det_q == '0) ? ST_FINISH : ST_TEST;
				ST_TEST:   state_q <= pass ? ST_DIV_T : ST_FINISH;
				ST_DIV_T: begin
					if (div_done) begin
						state_q <= t_ok ? ST_DIV_U : ST_FINISH;
					end
				end
				ST_DIV_U: begin
					if (div_done) begin
						state_q <= ST_DIV_V;
					end
				end
				ST_DIV_V: begin
					if (div_done) begin
						best_dist_q  <= t_q[DW-1:0];
						best_u_q     <= u_q;
						best_v_q     <= div_quo[UW-1:0];
						best_index_q <= tri_q;
						any_hit_q    <= 1'b1;
						state_q      <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_found_q  <= any_hit_q;
						out_data_q   <= any_hit_q
						              ? {best_index_q, best_v_q, best_u_q, best_dist_q} : '0;
						best_dist_q  <= limit_q;
						best_u_q     <= '0;
						best_v_q     <= '0;
						best_index_q <= '0;
						any_hit_q    <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// triangle payload and intermediate products
	always_ff @(posedge clk) begin
		if (accept) begin
			tri_q   <= s_axis_tdata[IW-1:0];
			final_q <= s_axis_tlast;
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= s_axis_tdata[IW+CW*(3+i) +: CW];
				e2_q[i] <= s_axis_tdata[IW+CW*(6+i) +: CW];
				tv_q[i] <= tv_new[i];
			end
		end
		if (store_s1.valid) begin
			unique case (store_s1.dst)
				DST_PV:  pv_q[store_s1.idx] <= acc[VW-1:0];
				DST_QV:  qv_q[store_s1.idx] <= acc[VW-1:0];
				DST_DET: det_q <= acc;
				DST_UN:  un_q  <= acc;
				DST_VN:  vn_q  <= acc;
				DST_TN:  tn_q  <= acc;
				default: ;
			endcase
		end
		if (state_q == ST_NORM && det_q[AW-1]) begin
			det_q <= -det_q;
			un_q  <= -un_q;
			vn_q  <= -vn_q;
			tn_q  <= -tn_q;
		end
		if (state_q == ST_DIV_T && div_done) begin
			t_q <= div_quo;
		end
		if (state_q == ST_DIV_U && div_done) begin
			u_q <= div_quo[UW-1:0];
		end
	end

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_busy)
		else $error("item taken while divider busy");

	a_commit_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (t_q <= {1'b0, best_dist_q}))
		else $error("hit committed beyond current limit");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("miss result carries nonzero data");

	a_div_only_in_div_states: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_T || state_q == ST_DIV_U || state_q == ST_DIV_V))
		else $error("divider finished outside a divide state");

endmodule

### sim/rtch_closest_hit_checker.sv
// Scoreboard for the ray/triangle closest-hit core: watches the triangle, result and
// register channels, predicts the closest hit of each ray and compares every result.
// Depends on rtch_pkg.
`timescale 1ns / 1ps

module rtch_closest_hit_checker
	import rtch_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IN_TW-1:0]    s_axis_tdata,
	input  logic                s_axis_tlast,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [OUT_TW-1:0]   m_axis_tdata,
	input  logic                m_axis_tuser,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CW-1:0]       cfg_data,
	output int                  fails,
	output int                  pending
);

	typedef logic signed [255:0] wint;

	typedef struct packed {
		logic          found;
		logic [DW-1:0] hdist;
		logic [UW-1:0] u;
		logic [UW-1:0] v;
		logic [IW-1:0] idx;
	} hit_t;

	hit_t           hit_queue[$];
	logic [CW-1:0]  ray_word[7];
	logic [DW-1:0]  best_dist;
	logic [UW-1:0]  best_u;
	logic [UW-1:0]  best_v;
	logic [IW-1:0]  best_idx;
	logic           any_hit;

	function automatic wint widen(input logic [CW-1:0] x);
		return wint'($signed(x));
	endfunction

	function automatic wint dot3(input wint a[3], input wint b[3]);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	task automatic cross3(input wint a[3], input wint b[3], output wint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endtask

	task automatic rearm();
		best_dist = ray_word[REG_START_LIMIT][DW-1:0];
		best_u    = '0;
		best_v    = '0;
		best_idx  = '0;
		any_hit   = 1'b0;
	endtask

	task automatic trace_triangle(input logic [IW-1:0] id, input logic [8:0][CW-1:0] co);
		wint org[3], dir[3], e1[3], e2[3], tv[3], pv[3], qv[3];
		wint det, un, vn, tn, lim;
		for (int i = 0; i < 3; i++) begin
			org[i] = widen(ray_word[REG_ORIGIN_X + i]);
			dir[i] = widen(ray_word[REG_DIR_X + i]);
			e1[i]  = widen(co[3 + i]);
			e2[i]  = widen(co[6 + i]);
			tv[i]  = org[i] - widen(co[i]);
		end
		cross3(dir, e2, pv);
		det = dot3(e1, pv);
		un  = dot3(tv, pv);
		cross3(tv, e1, qv);
		vn  = dot3(dir, qv);
		tn  = dot3(e2, qv);
		if (det == 0)
			return;
		if (det < 0) begin
			det = -det;
			un  = -un;
			vn  = -vn;
			tn  = -tn;
		end
		lim = (wint'(best_dist) + 1) * det;
		if (un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn >= 0 &&
				(tn <<< FB) < lim) begin
			best_dist = DW'((tn <<< FB) / det);
			best_u    = UW'((un <<< FB) / det);
			best_v    = UW'((vn <<< FB) / det);
			best_idx  = id;
			any_hit   = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int   errs;
		hit_t got, exp_hit;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < 7; i++)
				ray_word[i] = '0;
			ray_word[REG_DIR_Z]       = DIR_Z_RESET;
			ray_word[REG_START_LIMIT] = CW'(LIMIT_RESET);
			rearm();
			hit_queue.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= REG_START_LIMIT) begin
				ray_word[cfg_index] = (cfg_index == REG_START_LIMIT) ?
					{1'b0, cfg_data[DW-1:0]} : cfg_data;
				rearm();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				trace_triangle(s_axis_tdata[IW-1:0], s_axis_tdata[IW +: 9 * CW]);
				if (s_axis_tlast) begin
					exp_hit.found = any_hit;
					exp_hit.hdist = any_hit ? best_dist : '0;
					exp_hit.u     = any_hit ? best_u : '0;
					exp_hit.v     = any_hit ? best_v : '0;
					exp_hit.idx   = any_hit ? best_idx : '0;
					hit_queue.push_back(exp_hit);
					rearm();
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.found = m_axis_tuser;
				got.hdist = m_axis_tdata[DW-1:0];
				got.u     = m_axis_tdata[DW +: UW];
				got.v     = m_axis_tdata[DW + UW +: UW];
				got.idx   = m_axis_tdata[DW + 2 * UW +: IW];
				if (hit_queue.size() == 0) begin
					$error("result item with none expected");
					errs++;
				end else begin
					exp_hit = hit_queue.pop_front();
					if (got.found !== exp_hit.found) begin
						$error("found: expected %0d, got %0d", exp_hit.found, got.found);
						errs++;
					end
					if (got.hdist !== exp_hit.hdist) begin
						$error("hit_dist: expected %0d, got %0d", exp_hit.hdist, got.hdist);
						errs++;
					end
					if (got.u !== exp_hit.u) begin
						$error("bary_u: expected %0d, got %0d", exp_hit.u, got.u);
						errs++;
					end
					if (got.v !== exp_hit.v) begin
						$error("bary_v: expected %0d, got %0d", exp_hit.v, got.v);
						errs++;
					end
					if (got.idx !== exp_hit.idx) begin
						$error("hit_index: expected %0d, got %0d", exp_hit.idx, got.idx);
						errs++;
					end
				end
			end
			fails   <= fails + errs;
			pending <= hit_queue.size();
		end
	end

endmodule

### sim/ray_triangle_closest_hit_core_tb.sv
// Testbench top for ray_triangle_closest_hit_core: drives rays and triangle streams
// with random gaps and stalls and gives the verdict. Depends on rtch_pkg and
// rtch_closest_hit_checker.
`timescale 1ns / 1ps

module ray_triangle_closest_hit_core_tb;
	import rtch_pkg::*;

	localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE = 130;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int ONE = 1 << FB;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [IN_TW-1:0]    s_axis_tdata = '0;
	logic                s_axis_tlast = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [OUT_TW-1:0]   m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CW-1:0]       cfg_data = '0;
	int                  fails;
	int                  pending;

	bit                  tx_quiet = 1'b0;
	bit                  rx_quiet = 1'b0;
	bit                  rx_hold = 1'b0;
	int                  rx_gap = 0;
	longint              cycles = 0;
	logic [CW-1:0]       ray[7];

	ray_triangle_closest_hit_core u_top (.*);

	rtch_closest_hit_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL ray_triangle_closest_hit_core");
			$finish;
		end
	end

	// result side: random stall per item, plus one long hold-off
	always @(posedge clk) begin
		if (m_axis_tready && m_axis_tvalid)
			rx_gap = rx_quiet ? 0 : $urandom_range(0, 15);
		else if (rx_gap > 0)
			rx_gap--;
		m_axis_tready <= arst_n && rx_gap == 0 && !rx_hold;
	end

	initial begin
		@(posedge arst_n);
		repeat (20000) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (1500) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_tri(input logic [IW-1:0] id, input logic [8:0][CW-1:0] co,
			input bit last);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {co, id};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_START_LIMIT)
			ray[idx] = (idx == REG_START_LIMIT) ? {1'b0, val[DW-1:0]} : val;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// vertex placed so the ray meets the plane near (t, u, v)
	function automatic logic [8:0][CW-1:0] aimed_tri();
		logic [8:0][CW-1:0] co;
		longint t, u, v, e1, e2, q;
		t = $urandom_range(0, 4 * ONE);
		if ($urandom_range(0, 7) == 0)
			t = -t;
		u = $urandom_range(0, ONE);
		v = $urandom_range(0, ONE - u);
		for (int i = 0; i < 3; i++) begin
			e1 = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			e2 = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			q  = longint'($signed(ray[REG_ORIGIN_X + i]))
				+ ((longint'($signed(ray[REG_DIR_X + i])) * t) >>> FB);
			co[i]     = CW'(q - ((u * e1) >>> FB) - ((v * e2) >>> FB));
			co[3 + i] = CW'(e1);
			co[6 + i] = CW'(e2);
		end
		return co;
	endfunction

	function automatic logic [8:0][CW-1:0] noise_tri(input bit full);
		logic [8:0][CW-1:0] co;
		for (int i = 0; i < 9; i++)
			co[i] = full ? $urandom : CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
		return co;
	endfunction

	function automatic logic [8:0][CW-1:0] geom(input int px, input int py, input int pz,
			input int ax, input int ay, input int bx, input int by);
		return {32'sd0, CW'(by), CW'(bx), 32'sd0, CW'(ay), CW'(ax), CW'(pz), CW'(py), CW'(px)};
	endfunction

	task automatic run_phase(input int p, input int n_items);
		logic [CW-1:0] val;
		int left, len;
		logic [8:0][CW-1:0] co;
		settle();
		for (int r = 0; r <= REG_UNUSED; r++) begin
			case (p)
				0: val = 32'h8000_0000;
				1: val = 32'h7FFF_FFFF;
				default: begin
					if (r <= REG_ORIGIN_Z)
						val = CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
					else if (r <= REG_DIR_Z)
						val = CW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
					else if (r == REG_START_LIMIT)
						val = ($urandom_range(0, 5) == 0) ? $urandom
							: $urandom_range(0, 1 << 20);
					else
						val = $urandom;
				end
			endcase
			if (p == 0 && r == REG_START_LIMIT)
				val = '0;
			write_reg(r[CFG_IW-1:0], val);
		end
		cfg_valid <= 1'b0;
		tx_quiet = (p % 4 == 3);
		rx_quiet = (p % 5 == 2);
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(1, 6);
			if (len > left)
				len = left;
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 19))
					0, 1, 2:    co = noise_tri(1'b1);
					3, 4:       co = noise_tri(1'b0);
					default:    co = aimed_tri();
				endcase
				send_tri(IW'($urandom), co, k == len - 1);
			end
			left -= len;
		end
	endtask

	initial begin
		logic [8:0][CW-1:0] co;
		ray[REG_ORIGIN_X]    = '0;
		ray[REG_ORIGIN_Y]    = '0;
		ray[REG_ORIGIN_Z]    = '0;
		ray[REG_DIR_X]       = '0;
		ray[REG_DIR_Y]       = '0;
		ray[REG_DIR_Z]       = DIR_Z_RESET;
		ray[REG_START_LIMIT] = CW'(LIMIT_RESET);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ray: origin 0, direction +z, limit 1.0
		co = geom(-ONE, -ONE, ONE / 2, 2 * ONE, 0, 0, 2 * ONE);
		send_tri(16'd1, co, 1'b0);
		send_tri(16'd2, co, 1'b1);                              // equal t, later wins
		send_tri(16'd3, geom(-ONE, -ONE, ONE / 2, 0, 2 * ONE, 2 * ONE, 0), 1'b1);
		send_tri(16'd4, geom(-ONE, -ONE, ONE / 2, 0, 0, 0, 2 * ONE), 1'b1);
		send_tri(16'd5, geom(-ONE, -ONE, -ONE / 2, 2 * ONE, 0, 0, 2 * ONE), 1'b1);
		send_tri(16'hFFFF, geom(-ONE, -ONE, ONE, 2 * ONE, 0, 0, 2 * ONE), 1'b1);
		send_tri(16'd0, geom(-ONE, -ONE, ONE + 1, 2 * ONE, 0, 0, 2 * ONE), 1'b1);
		send_tri(16'd6, geom(ONE, ONE, ONE / 2, 2 * ONE, 0, 0, 2 * ONE), 1'b1);
		send_tri(16'd7, geom(0, 0, ONE / 4, ONE, 0, 0, ONE), 1'b0);
		send_tri(16'd8, geom(0, 0, ONE / 8, 0, ONE, ONE, 0), 1'b1);
		send_tri('0, '0, 1'b1);
		send_tri('1, '1, 1'b1);
		send_tri(16'h8000, {9{32'h8000_0000}}, 1'b1);
		send_tri(16'h7FFF, {9{32'h7FFF_FFFF}}, 1'b1);

		for (int p = 0; p < 15; p++)
			run_phase(p, (p < 2) ? 40 : 105);

		settle();
		if (fails == 0 && pending == 0)
			$display("PASS ray_triangle_closest_hit_core");
		else
			$display("FAIL ray_triangle_closest_hit_core");
		$finish;
	end

endmodule

### ray_triangle_closest_hit_core.f
rtl/rtch_pkg.sv
rtl/rtch_mac.sv
rtl/rtch_div.sv
rtl/ray_triangle_closest_hit_core.sv
sim/rtch_closest_hit_checker.sv
sim/ray_triangle_closest_hit_core_tb.sv
